/* hdl/ofmr_pkg.sv */
// Shared types, field widths and register codes for the frame mean removal unit.
`timescale 1ns / 1ps

package ofmr_pkg;

  localparam int VAL_W     = 23;  // result value, six fractional bits
  localparam int POS_W     = 6;   // position within padded frame
  localparam int FIDX_W    = 16;  // frame counter
  localparam int LEN_W     = 7;   // frame length / fill count
  localparam int SHIFT_W   = 8;   // frame shift / shift phase
  localparam int LOG_W     = 3;   // log2 of padded size
  localparam int FRAC_BITS = 6;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [LEN_W-1:0]     FILL_SAT        = 7'd64;
  localparam logic [SHIFT_W-1:0]   SHIFT_RST       = 8'd32;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_LENGTH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_SHIFT  = 1'b1;

  typedef struct packed {
    logic accept;   // input transfer this cycle
    logic sum;      // read ring and accumulate frame sum
    logic mean_ld;  // latch scaled mean, prefetch first entry
    logic emit;     // stream padded frame to the output register
  } dp_cmd_t;

  typedef struct packed {
    logic frame_end;  // current input sample closes a frame
    logic sum_done;   // all frame entries accumulated
    logic emit_done;  // last padded entry loaded into output register
  } dp_sts_t;

  // ceil(log2(l)) for 1 <= l <= 64
  function automatic logic [LOG_W-1:0] ceil_log2(input logic [LEN_W-1:0] l);
    logic [LOG_W-1:0] r;
    r = '0;
    for (int k = 0; k < LEN_W; k++) begin
      if (LEN_W'(1 << k) < l) r = r + 1'b1;
    end
    return r;
  endfunction

endpackage

/* hdl/ofmr_ram.sv */
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module ofmr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/ofmr_datapath.sv */
// Datapath: sample ring, frame counters, sum/mean arithmetic and output register.
`timescale 1ns / 1ps

module ofmr_datapath import ofmr_pkg::*; #(
  parameter int MAX_PADDED  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_start_of_signal,
  input  dp_cmd_t                       cmd,
  output dp_sts_t                       sts,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic signed [VAL_W-1:0]       out_value,
  output logic [POS_W-1:0]              out_position,
  output logic [FIDX_W-1:0]             out_frame_index,
  output logic                          out_last_of_frame
);

  // ring depth is the largest power of two not above MAX_PADDED
  localparam int AW    = $clog2(MAX_PADDED + 1) - 1;
  localparam int DEPTH = 1 << AW;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(DEPTH);
  localparam logic [LOG_W-1:0] MAX_LOG = LOG_W'(AW);

  // configuration
  logic [LEN_W-1:0]   len_r;
  logic [LOG_W-1:0]   pad_r;
  logic [SHIFT_W-1:0] shift_r;
  logic [LEN_W-1:0]   len_in;
  logic [SHIFT_W-1:0] shift_eff;
  logic [LEN_W-1:0]   psize;

  // counters and pointers
  logic [LEN_W-1:0]   filled_r;
  logic [SHIFT_W-1:0] phase_r;
  logic [FIDX_W-1:0]  fc_r;
  logic [AW-1:0]      wp_r;
  logic [AW-1:0]      oldest_r;
  logic [FIDX_W-1:0]  fidx_r;
  logic [LEN_W-1:0]   idx_r;
  logic [LEN_W-1:0]   j_r;
  logic               pend_r;
  logic               data_ok_r;

  logic [LEN_W-1:0]   fill_b, fill_n;
  logic [SHIFT_W-1:0] phase_b, phase_n, ph1;
  logic [FIDX_W-1:0]  fc_b;
  logic               fe;

  // arithmetic
  logic signed [VAL_W-1:0]       acc_r;
  logic signed [VAL_W-1:0]       mean_r;
  logic signed [VAL_W-1:0]       rd_ext;
  logic signed [VAL_W-1:0]       value_nxt;
  logic [SAMPLE_BITS-1:0]        rd_data;
  logic signed [SAMPLE_BITS-1:0] rd_s;
  logic [AW-1:0]                 rd_addr;
  logic                          issue;
  logic                          load;
  logic                          is_last;

  // output register
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] out_value_r;
  logic [POS_W-1:0]        out_pos_r;
  logic [FIDX_W-1:0]       out_fidx_r;
  logic                    out_last_r;

  // effective length: zero means one, clipped to the ring depth
  always_comb begin
    len_in = cfg_data[LEN_W-1:0];
    if (len_in == '0) begin
      len_in = LEN_W'(1);
    end else if (len_in > MAX_LEN) begin
      len_in = MAX_LEN;
    end
  end

  assign shift_eff = (shift_r == '0) ? SHIFT_W'(1) : shift_r;
  assign psize     = LEN_W'(1) << pad_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= MAX_LEN;
      pad_r   <= MAX_LOG;
      shift_r <= SHIFT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_LENGTH: begin
          len_r <= len_in;
          pad_r <= ceil_log2(len_in);
        end
        REG_FRAME_SHIFT: begin
          shift_r <= cfg_data[SHIFT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // frame boundary for the sample on the input
  always_comb begin
    fill_b  = in_start_of_signal ? '0 : filled_r;
    phase_b = in_start_of_signal ? '0 : phase_r;
    fc_b    = in_start_of_signal ? '0 : fc_r;
    fill_n  = (fill_b < FILL_SAT) ? fill_b + 1'b1 : fill_b;
    ph1     = phase_b + 1'b1;
    if (fill_b < len_r) begin
      fe      = (fill_n == len_r);
      phase_n = fe ? '0 : phase_b;
    end else begin
      fe      = (ph1 >= shift_eff);
      phase_n = fe ? '0 : ph1;
    end
  end

  assign sts.frame_end = fe;

  // ring read: sum pass walks idx, emit pass walks j with one entry lookahead
  assign issue       = cmd.sum && (idx_r < len_r);
  assign out_valid   = out_valid_r;
  assign load        = cmd.emit && data_ok_r && (!out_valid_r || out_ready);
  assign is_last     = (j_r == psize - 1'b1);
  assign sts.sum_done  = (idx_r == len_r) && !pend_r;
  assign sts.emit_done = load && is_last;

  always_comb begin
    if (cmd.sum) begin
      rd_addr = oldest_r + idx_r[AW-1:0];
    end else begin
      rd_addr = oldest_r + j_r[AW-1:0] + AW'(load);
    end
  end

  ofmr_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (cmd.accept),
    .waddr (wp_r),
    .wdata (in_sample),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign rd_s      = rd_data;
  assign rd_ext    = VAL_W'(rd_s);
  assign value_nxt = (j_r < len_r) ? (rd_ext <<< FRAC_BITS) - mean_r : -mean_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r    <= '0;
      phase_r     <= '0;
      fc_r        <= '0;
      wp_r        <= '0;
      idx_r       <= '0;
      j_r         <= '0;
      pend_r      <= 1'b0;
      data_ok_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        wp_r     <= wp_r + 1'b1;
        filled_r <= fill_n;
        phase_r  <= phase_n;
        fc_r     <= fe ? fc_b + 1'b1 : fc_b;
        if (fe) begin
          idx_r <= '0;
          j_r   <= '0;
        end
      end
      if (issue) begin
        idx_r <= idx_r + 1'b1;
      end
      pend_r    <= issue;
      data_ok_r <= cmd.mean_ld || cmd.emit;
      if (load) begin
        j_r <= j_r + 1'b1;
      end
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && fe) begin
      oldest_r <= wp_r + 1'b1 - len_r[AW-1:0];
      fidx_r   <= fc_b;
      acc_r    <= '0;
    end else if (pend_r) begin
      acc_r <= acc_r + rd_ext;
    end
    if (cmd.mean_ld) begin
      mean_r <= acc_r << (LOG_W'(FRAC_BITS) - pad_r);
    end
    if (load) begin
      out_value_r <= value_nxt;
      out_pos_r   <= j_r[POS_W-1:0];
      out_fidx_r  <= fidx_r;
      out_last_r  <= is_last;
    end
  end

  assign out_value         = out_value_r;
  assign out_position      = out_pos_r;
  assign out_frame_index   = out_fidx_r;
  assign out_last_of_frame = out_last_r;

`ifndef ASSERT_OFF
  a_pend_follows_sum: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> $past(cmd.sum))
    else $error("ring read pending without a sum command");

  a_data_ok_follows_prefetch: assert property (@(posedge clk) disable iff (!rst_n)
    data_ok_r |-> $past(cmd.mean_ld || cmd.emit))
    else $error("emit data marked good without a prefetch");

  a_out_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.emit))
    else $error("output loaded outside the emit pass");
`endif

endmodule

/* hdl/ofmr_ctrl.sv */
// Controller: sequences sample intake, frame sum, mean latch and frame emission.
`timescale 1ns / 1ps

module ofmr_ctrl import ofmr_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output dp_cmd_t cmd,
  input  dp_sts_t sts
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SUM  = 2'd1;
  localparam logic [1:0] ST_MEAN = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0] state_r, state_nxt;

  assign in_ready    = (state_r == ST_IDLE);
  assign cmd.accept  = in_ready && in_valid;
  assign cmd.sum     = (state_r == ST_SUM);
  assign cmd.mean_ld = (state_r == ST_MEAN);
  assign cmd.emit    = (state_r == ST_EMIT);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (cmd.accept && sts.frame_end) state_nxt = ST_SUM;
      end
      ST_SUM: begin
        if (sts.sum_done) state_nxt = ST_MEAN;
      end
      ST_MEAN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts.emit_done) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_sum_to_mean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM) && sts.sum_done |=> (state_r == ST_MEAN))
    else $error("sum pass did not hand over to mean latch");
`endif

endmodule

/* hdl/overlapping_frame_mean_removal_unit.sv */
// Top level: overlapping frame extraction with mean removal, controller plus datapath.
`timescale 1ns / 1ps

// Channel  | Direction | Handshake             | Payload
// ---------+-----------+-----------------------+---------------------------------------------
// in_      | input     | in_valid / in_ready   | sample, start_of_signal
// out_     | output    | out_valid / out_ready | value, position, frame_index, last_of_frame
// cfg_     | input     | cfg_we (no wait)      | cfg_index, cfg_data
//
// A sample that closes no frame leaves the controller idle and the input ready. A
// sample that closes a frame of L samples padded to P entries holds the input through
// the sum pass over its L samples and the mean latch, then P entries at one per
// cycle. Both passes go through the single read port of the sample ring.
// Output stalls stretch the emit pass cycle for cycle; the output register lets the
// next sample transfer while the last entry of a frame still waits.
// rst_n is synchronous and active low; the ring is not cleared (its entries are
// only read after being written since start of signal).

module overlapping_frame_mean_removal_unit import ofmr_pkg::*; #(
  parameter int MAX_PADDED  = 64,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // configuration writes
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_W-1:0]              cfg_data,
  // sample input
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          in_start_of_signal,
  // frame output
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VAL_W-1:0]       out_value,
  output logic [POS_W-1:0]              out_position,
  output logic [FIDX_W-1:0]             out_frame_index,
  output logic                          out_last_of_frame
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencing: idle -> sum -> mean -> emit -> idle
  ofmr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // ring, counters, mean arithmetic and output register
  ofmr_datapath #(
    .MAX_PADDED  (MAX_PADDED),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_sample          (in_sample),
    .in_start_of_signal (in_start_of_signal),
    .cmd                (cmd),
    .sts                (sts),
    .out_ready          (out_ready),
    .out_valid          (out_valid),
    .out_value          (out_value),
    .out_position       (out_position),
    .out_frame_index    (out_frame_index),
    .out_last_of_frame  (out_last_of_frame)
  );

`ifndef ASSERT_OFF
  // no new sample transfer while a frame is being summed, its mean latched or emitted
  a_no_intake_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.sum || cmd.mean_ld || cmd.emit) |-> !in_ready)
    else $error("input ready while a frame is in progress");

  // the final entry of a frame ends the emit pass
  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    sts.emit_done |=> out_valid && out_last_of_frame && !cmd.emit)
    else $error("last entry did not close the frame");
`endif

endmodule

/* tb/ofmr_frame_checker.sv */
// Watches the sample, frame and register ports, predicts each padded frame and compares it.
`timescale 1ns / 1ps

module ofmr_frame_checker import ofmr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic signed [15:0]      in_sample,
  input  logic                    in_start_of_signal,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [VAL_W-1:0] out_value,
  input  logic [POS_W-1:0]        out_position,
  input  logic [FIDX_W-1:0]       out_frame_index,
  input  logic                    out_last_of_frame,
  output int                      mismatches,
  output int                      outstanding
);

  localparam int RING_DEPTH = 64;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
    logic [FIDX_W-1:0]       frame_index;
    logic                    last;
  } padded_entry_t;

  padded_entry_t padded_entries_q[$];

  // shadow of the block state
  logic signed [15:0] ring [RING_DEPTH];
  logic [5:0]         wr_ptr;
  logic [LEN_W-1:0]   fill;
  logic [SHIFT_W-1:0] phase;
  logic [FIDX_W-1:0]  frame_no;
  logic [LOG_W-1:0]   pad_log;
  logic [LEN_W-1:0]   len_reg;
  logic [SHIFT_W-1:0] shift_reg;

  // zero length acts as one, oversize saturates to the ring depth
  function automatic int active_length();
    if (len_reg == 0) return 1;
    if (len_reg > RING_DEPTH) return RING_DEPTH;
    return len_reg;
  endfunction

  function automatic int active_shift();
    return (shift_reg == 0) ? 1 : shift_reg;
  endfunction

  function automatic void compare_field(string name, logic signed [31:0] want,
                                        logic signed [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Store one sample; if it closes a frame, queue the padded, mean-removed entries.
  task automatic absorb_sample(input logic signed [15:0] s, input logic restart);
    int            l;
    int            p;
    int            first;
    int            sum;
    int            mean64;
    int            v;
    bit            closes;
    logic [LEN_W-1:0] prev;
    padded_entry_t e;
    closes = 1'b0;
    sum = 0;
    if (restart) begin
      fill = '0;
      phase = '0;
      frame_no = '0;
    end
    ring[wr_ptr] = s;
    wr_ptr = wr_ptr + 1'b1;
    l = active_length();
    prev = fill;
    if (fill < RING_DEPTH) fill = fill + 1'b1;
    if (prev < l) begin
      if (fill == l) begin
        closes = 1'b1;
        phase = '0;
      end
    end else begin
      phase = phase + 1'b1;
      if (phase >= active_shift()) begin
        closes = 1'b1;
        phase = '0;
      end
    end
    if (closes) begin
      p = 1 << pad_log;
      first = (int'(wr_ptr) - l) & (RING_DEPTH - 1);
      for (int i = 0; i < l; i++) sum += ring[(first + i) & (RING_DEPTH - 1)];
      mean64 = sum * (RING_DEPTH / p);
      for (int i = 0; i < p; i++) begin
        if (i < l) v = ring[(first + i) & (RING_DEPTH - 1)] * 64 - mean64;
        else v = -mean64;
        e.value       = VAL_W'(v);
        e.position    = POS_W'(i);
        e.frame_index = frame_no;
        e.last        = (i == p - 1);
        padded_entries_q.push_back(e);
      end
      frame_no = frame_no + 1'b1;
    end
  endtask

  always @(posedge clk) begin
    padded_entry_t want;
    if (!rst_n) begin
      wr_ptr    = '0;
      fill      = '0;
      phase     = '0;
      frame_no  = '0;
      len_reg   = FILL_SAT;
      shift_reg = SHIFT_RST;
      pad_log   = LOG_W'(6);
      padded_entries_q.delete();
      mismatches = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_FRAME_LENGTH) begin
          len_reg = cfg_data[LEN_W-1:0];
          pad_log = '0;
          while ((1 << pad_log) < active_length()) pad_log = pad_log + 1'b1;
        end else if (cfg_index == REG_FRAME_SHIFT) begin
          shift_reg = cfg_data;
        end
      end
      if (in_valid && in_ready) absorb_sample(in_sample, in_start_of_signal);
      if (out_valid && out_ready) begin
        if (padded_entries_q.size() == 0) begin
          $error("unexpected result: value %0d, position %0d, frame_index %0d",
                 out_value, out_position, out_frame_index);
          mismatches++;
        end else begin
          want = padded_entries_q.pop_front();
          compare_field("value", want.value, out_value);
          compare_field("position", want.position, out_position);
          compare_field("frame_index", want.frame_index, out_frame_index);
          compare_field("last_of_frame", want.last, out_last_of_frame);
        end
      end
      outstanding <= padded_entries_q.size();
    end
  end

endmodule

/* tb/overlapping_frame_mean_removal_unit_tb.sv */
// Stimulus and verdict for the overlapping frame mean removal unit.
`timescale 1ns / 1ps

// Flow:
//   reset, directed samples (extremes, restart mid-signal, zero length and shift),
//   then random phases, each with its own frame length and shift. Phases are
//   separated by a drain: the sender stops, every predicted entry must come back,
//   and only then are the registers rewritten. Phases that skip the restart
//   carry the fill count across a length change, which exercises mid-signal
//   reconfiguration.
// Flow control:
//   first third - sender idles 29%, receiver 86%
//   second third - sender 86%, receiver 29%
//   last third - no idling, plus one long receiver hold-off so the block backs up
//   and stalls its input.
// The checker instance predicts and compares; this module only drives and judges.

module overlapping_frame_mean_removal_unit_tb;
  import ofmr_pkg::*;

  localparam int SAMPLE_W = 16;

  logic                          clk;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = REG_FRAME_LENGTH;
  logic [CFG_W-1:0]              cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic signed [SAMPLE_W-1:0]    in_sample = '0;
  logic                          in_start_of_signal = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [VAL_W-1:0]       out_value;
  logic [POS_W-1:0]              out_position;
  logic [FIDX_W-1:0]             out_frame_index;
  logic                          out_last_of_frame;

  int mismatches;
  int outstanding;

  // flow-control knobs, read by the sender task and the receiver process
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int backlog_reqs = 0;  // bumped to request one long receiver hold-off
  bit hold_in_phase = 0; // next phase starts a hold-off once its registers are set

  overlapping_frame_mean_removal_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .in_start_of_signal(in_start_of_signal),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_value         (out_value),
    .out_position      (out_position),
    .out_frame_index   (out_frame_index),
    .out_last_of_frame (out_last_of_frame)
  );

  ofmr_frame_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .in_start_of_signal(in_start_of_signal),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_value         (out_value),
    .out_position      (out_position),
    .out_frame_index   (out_frame_index),
    .out_last_of_frame (out_last_of_frame),
    .mismatches        (mismatches),
    .outstanding       (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Hard stop: far beyond the slowest legal run.
  initial begin
    #12_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Receiver: random ready, or a long counted hold-off when one is requested.
  initial begin
    int hold_left;
    int seen;
    hold_left = 0;
    seen = 0;
    forever begin
      @(posedge clk);
      if (seen != backlog_reqs) begin
        seen = backlog_reqs;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Both registers back to back; cfg_we stays high across the two writes.
  task automatic program_frame(input int len, input int shift);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_LENGTH;
    cfg_data  <= CFG_W'(len);
    @(posedge clk);
    cfg_index <= REG_FRAME_SHIFT;
    cfg_data  <= CFG_W'(shift);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // One sample transfer; optional idle cycles first. Valid is only dropped
  // when a gap is actually taken.
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] s, input logic restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_sample          <= s;
    in_start_of_signal <= restart;
    do @(posedge clk); while (!in_ready);
  endtask

  // Sender pauses until every predicted entry is back, then lets the pipeline settle.
  task automatic drain_frames();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (16) @(posedge clk);
  endtask

  // restart_odds: 1 in N samples restarts the signal; 0 means never.
  task automatic run_phase(input int len, input int shift, input int count,
                           input bit fresh, input int restart_odds);
    logic signed [SAMPLE_W-1:0] s;
    logic                       restart;
    drain_frames();
    program_frame(len, shift);
    // receiver stalls while the sender keeps offering samples
    if (hold_in_phase) begin
      hold_in_phase = 0;
      backlog_reqs++;
    end
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(7) == 0) s = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      else s = SAMPLE_W'($urandom);
      restart = (k == 0 && fresh) ||
                (restart_odds != 0 && $urandom_range(restart_odds - 1) == 0);
      push_sample(s, restart);
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 29;
    recv_idle_pct = 86;

    // Directed: length 3 pads to 4, shift 2. Full-scale runs, sign extremes,
    // alternating bit patterns, then a restart in the middle of the signal.
    program_frame(3, 2);
    push_sample(16'sh7fff, 1'b1);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh0000, 1'b0);
    push_sample(-16'sd1, 1'b0);
    push_sample(16'sd1, 1'b0);
    push_sample(16'sh5555, 1'b0);
    push_sample(16'shaaaa, 1'b0);
    push_sample(16'sd12345, 1'b1);
    push_sample(-16'sd12345, 1'b0);
    push_sample(16'sd7, 1'b0);
    push_sample(-16'sd7, 1'b0);
    drain_frames();

    // zero length and zero shift both act as one: a single zero per sample
    program_frame(0, 0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh7fff, 1'b0);
    push_sample(16'sd100, 1'b0);

    // random phases, slow receiver
    run_phase(1, 1, 20, 1'b1, 0);
    run_phase(3, 1, 20, 1'b0, 40);
    run_phase(5, 3, 25, 1'b0, 40);
    run_phase(17, 7, 25, 1'b0, 60);

    // slow sender
    send_idle_pct = 86;
    recv_idle_pct = 29;
    run_phase(9, 255, 15, 1'b0, 0);
    run_phase(2, 2, 20, 1'b1, 30);
    run_phase(33, 5, 35, 1'b0, 0);
    run_phase(0, 0, 15, 1'b0, 20);

    // no idling: oversize length saturates to 64 with shift 1, then a backlog
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(127, 1, 68, 1'b1, 0);
    hold_in_phase = 1;
    run_phase(8, 1, 20, 1'b0, 0);
    run_phase(64, 32, 10, 1'b0, 0);

    drain_frames();
    if (mismatches == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule

/* files.f */
hdl/ofmr_pkg.sv
hdl/ofmr_ram.sv
hdl/ofmr_datapath.sv
hdl/ofmr_ctrl.sv
hdl/overlapping_frame_mean_removal_unit.sv
tb/ofmr_frame_checker.sv
tb/overlapping_frame_mean_removal_unit_tb.sv
